// ===== hw/rtl/bap_pkg.sv =====
package bap_pkg;

   // Sizing of the report store and packet window
   localparam int MAX_REPORTS      = 32;
   localparam int MAX_PACKET_BYTES = 256;
   localparam int ADDR_BYTES       = 6;

   localparam int REP_W = $clog2(MAX_REPORTS);
   localparam int CNT_W = $clog2(MAX_REPORTS + 1);
   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int SUM_W = 13;
   localparam int FC_W  = 13;
   localparam int APOS_W = 3;

   // HCI event codes
   localparam logic [7:0] EVT_LE_META    = 8'h3E;
   localparam logic [7:0] SUBEVT_ADV_REP = 8'h02;

   // Register map
   localparam int         CSR_ADDR_W             = 3;
   localparam logic [0:0] CSR_IDX_RSSI_THRESHOLD = 1'b0;

   // Controller states: parse phases, rejected packet, result sequencing
   typedef enum logic [3:0] {
      ST_HEADER,
      ST_TYPES,
      ST_ADDR,
      ST_LENS,
      ST_DATA,
      ST_RSSI,
      ST_DONE,
      ST_SKIP,
      ST_SCAN,
      ST_SHOW
   } ctrl_state_type;

   typedef struct packed {
      logic pos_inc;
      logic take_count;
      logic fc_inc;
      logic fc_clr;
      logic addr_wr;
      logic sum_add;
      logic rssi_wr;
      logic idx_inc;
      logic mem_rd;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic pos_full;
      logic pos_is1;
      logic pos_is3;
      logic pos_is4;
      logic code_ok;
      logic sub_ok;
      logic count_ok;
      logic count_zero;
      logic types_end;
      logic addr_end;
      logic lens_end;
      logic sum_next_zero;
      logic data_end;
      logic rssi_end;
      logic scan_end;
      logic scan_hit;
   } dp_stat_type;

endpackage

// ===== hw/rtl/bap_dpath.sv =====
module bap_dpath import bap_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        rx_byte,
   input  logic signed [7:0] rssi_threshold,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   output logic [47:0]       device_address,
   output logic [REP_W-1:0]  report_index,
   output logic              last_of_event
);

   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [FC_W-1:0]        fc_ff, fc_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [REP_W-1:0]       rep_ff, rep_in;
   logic [APOS_W-1:0]      apos_ff, apos_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [MAX_REPORTS-1:0] flags_ff, flags_in;
   logic [47:0]            rd_addr_ff;
   logic [47:0]            addr_mem [MAX_REPORTS];

   logic [FC_W:0]          fc_plus1;
   logic [SUM_W:0]         sum_next;
   logic signed [7:0]      strength;
   logic                   rssi_pass;
   logic                   more_after;

   assign fc_plus1  = {1'b0, fc_ff} + {{FC_W{1'b0}}, 1'b1};
   assign sum_next  = {1'b0, sum_ff} + {{(SUM_W - 7){1'b0}}, rx_byte};
   assign strength  = signed'(rx_byte + 8'd1);
   assign rssi_pass = (rssi_threshold == 8'sd0) || (strength >= rssi_threshold);

   // Status toward the controller
   always_comb begin
      stat.pos_full      = pos_ff >= POS_W'(MAX_PACKET_BYTES);
      stat.pos_is1       = pos_ff == POS_W'(1);
      stat.pos_is3       = pos_ff == POS_W'(3);
      stat.pos_is4       = pos_ff == POS_W'(4);
      stat.code_ok       = rx_byte == EVT_LE_META;
      stat.sub_ok        = rx_byte == SUBEVT_ADV_REP;
      stat.count_ok      = rx_byte <= 8'(MAX_REPORTS);
      stat.count_zero    = rx_byte == 8'd0;
      stat.types_end     = fc_plus1 >= (FC_W + 1)'({count_ff, 1'b0});
      stat.addr_end      = (apos_ff == APOS_W'(ADDR_BYTES - 1)) &&
                           (({1'b0, rep_ff} + CNT_W'(1)) == count_ff);
      stat.lens_end      = fc_plus1 >= (FC_W + 1)'(count_ff);
      stat.sum_next_zero = sum_next == '0;
      stat.data_end      = fc_plus1 >= (FC_W + 1)'(sum_ff);
      stat.rssi_end      = fc_plus1 >= (FC_W + 1)'(count_ff);
      stat.scan_end      = idx_ff >= count_ff;
      stat.scan_hit      = flags_ff[idx_ff[REP_W-1:0]];
   end

   // Next values of the per-packet counters
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      fc_in    = fc_ff;
      sum_in   = sum_ff;
      rep_in   = rep_ff;
      apos_in  = apos_ff;
      idx_in   = idx_ff;
      flags_in = flags_ff;
      if (cmd.clear) begin
         pos_in   = '0;
         count_in = '0;
         fc_in    = '0;
         sum_in   = '0;
         rep_in   = '0;
         apos_in  = '0;
         idx_in   = '0;
         flags_in = '0;
      end else begin
         if (cmd.pos_inc) pos_in = pos_ff + POS_W'(1);
         if (cmd.take_count) count_in = rx_byte[CNT_W-1:0];
         if (cmd.fc_clr) fc_in = '0;
         else if (cmd.fc_inc) fc_in = fc_plus1[FC_W-1:0];
         if (cmd.sum_add) sum_in = sum_next[SUM_W-1:0];
         // advance byte lane, then report slot
         if (cmd.addr_wr) begin
            if (apos_ff == APOS_W'(ADDR_BYTES - 1)) begin
               apos_in = '0;
               rep_in  = rep_ff + REP_W'(1);
            end else begin
               apos_in = apos_ff + APOS_W'(1);
            end
         end
         if (cmd.rssi_wr) flags_in[fc_ff[REP_W-1:0]] = rssi_pass;
         if (cmd.idx_inc) idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
         fc_ff    <= '0;
         sum_ff   <= '0;
         rep_ff   <= '0;
         apos_ff  <= '0;
         idx_ff   <= '0;
         flags_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
         fc_ff    <= fc_in;
         sum_ff   <= sum_in;
         rep_ff   <= rep_in;
         apos_ff  <= apos_in;
         idx_ff   <= idx_in;
         flags_ff <= flags_in;
      end
   end

   // Address store: byte-lane write, registered read
   always_ff @(posedge clock) begin
      if (cmd.addr_wr) addr_mem[rep_ff][{apos_ff, 3'b000} +: 8] <= rx_byte;
      if (cmd.mem_rd) rd_addr_ff <= addr_mem[idx_ff[REP_W-1:0]];
   end

   // Flag any passing report beyond the one on display
   always_comb begin
      more_after = 1'b0;
      for (int j = 0; j < MAX_REPORTS; j++) begin
         if (flags_ff[j] && (CNT_W'(j) > idx_ff)) more_after = 1'b1;
      end
   end

   assign device_address = rd_addr_ff;
   assign report_index   = idx_ff[REP_W-1:0];
   assign last_of_event  = !more_after;

   a_rssi_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rssi_wr |-> fc_ff < FC_W'(MAX_REPORTS))
      else $error("rssi flag written beyond report slots");

   a_addr_lane: assert property (@(posedge clock) disable iff (reset)
      cmd.addr_wr |-> apos_ff < APOS_W'(ADDR_BYTES))
      else $error("address byte lane out of range");

   a_read_passing: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |-> flags_ff[idx_ff[REP_W-1:0]] && (idx_ff < count_ff))
      else $error("address read for a report that did not pass");

endmodule

// ===== hw/rtl/bap_ctrl.sv =====
module bap_ctrl import bap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tlast,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   ctrl_state_type parse_next;
   ctrl_state_type byte_next;
   logic           parsing;
   logic           req_fire;
   logic           consume;

   assign parsing  = (state_ff != ST_SCAN) && (state_ff != ST_SHOW);
   assign req_fire = req_tvalid && req_tready;
   assign consume  = req_fire && (state_ff != ST_SKIP) && !stat.pos_full;

   // Phase reached after consuming the current byte
   always_comb begin
      parse_next = state_ff;
      case (state_ff)
         ST_HEADER: begin
            if (stat.pos_is1 && !stat.code_ok) parse_next = ST_SKIP;
            else if (stat.pos_is3 && !stat.sub_ok) parse_next = ST_SKIP;
            else if (stat.pos_is4) begin
               if (!stat.count_ok) parse_next = ST_SKIP;
               else if (stat.count_zero) parse_next = ST_DONE;
               else parse_next = ST_TYPES;
            end
         end
         ST_TYPES: if (stat.types_end) parse_next = ST_ADDR;
         ST_ADDR:  if (stat.addr_end) parse_next = ST_LENS;
         ST_LENS: begin
            if (stat.lens_end) parse_next = stat.sum_next_zero ? ST_RSSI : ST_DATA;
         end
         ST_DATA:  if (stat.data_end) parse_next = ST_RSSI;
         ST_RSSI:  if (stat.rssi_end) parse_next = ST_DONE;
         default:  parse_next = state_ff;
      endcase
   end

   // Oversized packets drop into skip
   assign byte_next = (state_ff == ST_SKIP || stat.pos_full) ? ST_SKIP : parse_next;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SCAN: begin
            if (stat.scan_end) state_in = ST_HEADER;
            else if (stat.scan_hit) state_in = ST_SHOW;
         end
         ST_SHOW: if (rsp_tready) state_in = ST_SCAN;
         default: begin
            if (req_fire) begin
               if (req_tlast) state_in = (byte_next == ST_DONE) ? ST_SCAN : ST_HEADER;
               else state_in = byte_next;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_HEADER;
      else state_ff <= state_in;
   end

   // Datapath commands and handshake outputs
   always_comb begin
      cmd        = '0;
      req_tready = parsing;
      rsp_tvalid = state_ff == ST_SHOW;
      case (state_ff)
         ST_SCAN: begin
            if (stat.scan_end) cmd.clear = 1'b1;
            else if (stat.scan_hit) cmd.mem_rd = 1'b1;
            else cmd.idx_inc = 1'b1;
         end
         ST_SHOW: cmd.idx_inc = rsp_tready;
         default: begin
            cmd.pos_inc = consume;
            cmd.clear   = req_fire && req_tlast && (byte_next != ST_DONE);
            if (consume) begin
               case (state_ff)
                  ST_HEADER: cmd.take_count = stat.pos_is4 && stat.count_ok;
                  ST_TYPES: begin
                     cmd.fc_inc = 1'b1;
                     cmd.fc_clr = stat.types_end;
                  end
                  ST_ADDR: cmd.addr_wr = 1'b1;
                  ST_LENS: begin
                     cmd.sum_add = 1'b1;
                     cmd.fc_inc  = 1'b1;
                     cmd.fc_clr  = stat.lens_end;
                  end
                  ST_DATA: begin
                     cmd.fc_inc = 1'b1;
                     cmd.fc_clr = stat.data_end;
                  end
                  ST_RSSI: begin
                     cmd.rssi_wr = 1'b1;
                     cmd.fc_inc  = 1'b1;
                  end
                  default: cmd.pos_inc = consume;
               endcase
            end
         end
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input taken while a result is on display");

   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && !($past(state_ff) == ST_SCAN || $past(state_ff) == ST_SHOW)
      |-> $past(req_tvalid && req_tready && req_tlast))
      else $error("result scan started without a final byte");

   a_show_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |-> ($past(state_ff) == ST_SCAN || $past(state_ff) == ST_SHOW))
      else $error("result shown without a store read");

endmodule

// ===== hw/rtl/ble_adv_report_parser_unit.sv =====
// HCI LE advertising report parser.
// Input stream req_*: one HCI event byte per beat, type byte first, tlast on the
// final byte. Only LE meta / advertising-report events with at most 32 reports
// are kept; each report's address is stored and its RSSI judged against the
// rssi_threshold register (0 disables the filter).
// Output stream rsp_*: one beat per passing report, in report order, tlast on
// the final one. Nothing comes out for short, truncated, foreign or oversized
// (more than 256 bytes) packets.
// Throughput: one input byte per cycle while a packet is parsed. After the
// last byte req_tready drops and the result sequencer walks the report slots,
// one slot per cycle; a passing slot costs a store read plus the output beat,
// which waits for the receiver.
// A stalled receiver holds the current beat and the whole block; input resumes
// once the sequencer has passed the last slot and cleared the packet state.
// Reset (synchronous) clears the threshold and all parse state; the address
// store needs no clearing, as every slot read is written by the same packet.
module ble_adv_report_parser_unit import bap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // fields: rx_byte[7:0]
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // fields: device_address[47:0], report_index[52:48], zero fill[55:53]
   output logic [55:0]           rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic signed [7:0] thr_ff;
   logic              thr_sel;
   dp_cmd_type        cmd;
   dp_stat_type       stat;
   logic [47:0]       device_address;
   logic [REP_W-1:0]  report_index;

   // Register file: threshold only
   assign thr_sel    = csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_RSSI_THRESHOLD;
   assign csr_pready = 1'b1;
   assign csr_prdata = thr_sel ? {24'd0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= 8'sd0;
      else if (csr_psel && csr_penable && csr_pwrite && thr_sel) thr_ff <= csr_pwdata[7:0];
   end

   bap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bap_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .rx_byte        (req_tdata),
      .rssi_threshold (thr_ff),
      .cmd            (cmd),
      .stat           (stat),
      .device_address (device_address),
      .report_index   (report_index),
      .last_of_event  (rsp_tlast)
   );

   // Pack the result beat
   assign rsp_tdata = {3'b000, report_index, device_address};

endmodule

// ===== sim/adv_report_check.sv =====
// Watches the byte stream, the report stream and the register port of the
// advertising report parser. Predicts the report beats for every event and
// compares each accepted report beat with the oldest prediction.
module adv_report_check import bap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [55:0]           rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    reports_due
);

   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = CSR_ADDR_W'(4 * CSR_IDX_RSSI_THRESHOLD);

   typedef struct packed {
      logic [47:0] address;
      logic [4:0]  index;
      logic        last;
   } report_beat_type;

   report_beat_type        expected_reports[$];
   logic [47:0]            addr_slots[MAX_REPORTS];
   logic [MAX_REPORTS-1:0] pass_bits;
   ctrl_state_type         phase;
   int unsigned            byte_pos;
   int unsigned            n_reports;
   int unsigned            data_total;
   int unsigned            field_cnt;
   bit                     dropped;
   logic signed [7:0]      threshold;

   // Return all per-packet state to its idle value
   task automatic clear_packet();
      pass_bits  = '0;
      byte_pos   = 0;
      phase      = ST_HEADER;
      n_reports  = 0;
      data_total = 0;
      field_cnt  = 0;
      dropped    = 1'b0;
   endtask

   // Advance the parser by one packet byte; on the final byte queue the
   // passing reports, the last one marked
   task automatic take_byte(input logic [7:0] b, input logic fin);
      int unsigned       slot;
      logic signed [7:0] strength;
      report_beat_type   held;
      bit                have_held;
      if (!dropped) begin
         if (byte_pos >= MAX_PACKET_BYTES) begin
            dropped = 1'b1;
         end else begin
            case (phase)
               ST_HEADER: begin
                  if (byte_pos == 1 && b != EVT_LE_META) begin
                     dropped = 1'b1;
                  end else if (byte_pos == 3 && b != SUBEVT_ADV_REP) begin
                     dropped = 1'b1;
                  end else if (byte_pos == 4) begin
                     if (b > MAX_REPORTS) begin
                        dropped = 1'b1;
                     end else begin
                        n_reports = b;
                        field_cnt = 0;
                        phase     = (b == 8'd0) ? ST_DONE : ST_TYPES;
                     end
                  end
               end
               ST_TYPES: begin
                  field_cnt++;
                  if (field_cnt >= 2 * n_reports) begin
                     field_cnt = 0;
                     phase     = ST_ADDR;
                  end
               end
               ST_ADDR: begin
                  slot = field_cnt / ADDR_BYTES;
                  if (slot < MAX_REPORTS)
                     addr_slots[slot][8 * (field_cnt % ADDR_BYTES) +: 8] = b;
                  field_cnt++;
                  if (field_cnt >= ADDR_BYTES * n_reports) begin
                     field_cnt  = 0;
                     data_total = 0;
                     phase      = ST_LENS;
                  end
               end
               ST_LENS: begin
                  data_total += b;
                  field_cnt++;
                  if (field_cnt >= n_reports) begin
                     field_cnt = 0;
                     phase     = (data_total == 0) ? ST_RSSI : ST_DATA;
                  end
               end
               ST_DATA: begin
                  field_cnt++;
                  if (field_cnt >= data_total) begin
                     field_cnt = 0;
                     phase     = ST_RSSI;
                  end
               end
               ST_RSSI: begin
                  // the byte b carries rssi = b - 255, i.e. b + 1 in 8 bits
                  strength = b + 8'd1;
                  if (field_cnt < MAX_REPORTS)
                     pass_bits[field_cnt] = (threshold == 0) || (strength >= threshold);
                  field_cnt++;
                  if (field_cnt >= n_reports) phase = ST_DONE;
               end
               default: begin
               end
            endcase
            byte_pos++;
         end
      end

      if (fin) begin
         if (!dropped && phase == ST_DONE) begin
            have_held = 1'b0;
            for (slot = 0; slot < n_reports && slot < MAX_REPORTS; slot++) begin
               if (pass_bits[slot]) begin
                  if (have_held) expected_reports.push_back(held);
                  held.address = addr_slots[slot];
                  held.index   = 5'(slot);
                  held.last    = 1'b0;
                  have_held    = 1'b1;
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expected_reports.push_back(held);
            end
         end
         clear_packet();
      end
   endtask

   always @(posedge clock) begin
      report_beat_type want;
      if (reset) begin
         threshold = '0;
         foreach (addr_slots[s]) addr_slots[s] = '0;
         clear_packet();
         expected_reports.delete();
         mismatch_count = 0;
      end else begin
         // compare the report beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("report beat: expected none, got device_address %h report_index %0d",
                      rsp_tdata[47:0], rsp_tdata[52:48]);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_tdata[47:0] !== want.address) begin
                  $error("device_address: expected %h, got %h", want.address, rsp_tdata[47:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[52:48] !== want.index) begin
                  $error("report_index: expected %0d, got %0d", want.index, rsp_tdata[52:48]);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_of_event: expected %0b, got %0b", want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end

         if (req_tvalid && req_tready) take_byte(req_tdata, req_tlast);

         // track the threshold register
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == THRESHOLD_ADDR)
            threshold = csr_pwdata[7:0];
      end
      reports_due = expected_reports.size();
   end

endmodule

// ===== sim/tb.sv =====
module tb;
   import bap_pkg::*;

   localparam int ITEMS        = 160;
   localparam int IDLE_PCT     = 11;
   localparam int DRAIN_CYCLES = 2 * MAX_REPORTS + 12;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PKT_HDR      = 5;
   // two type bytes, address, length byte and RSSI byte of one report
   localparam int REPORT_BYTES = ADDR_BYTES + 4;

   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = CSR_ADDR_W'(4 * CSR_IDX_RSSI_THRESHOLD);
   localparam logic [7:0] EVT_CMD_COMPLETE = 8'h0E;
   localparam logic [7:0] SUBEVT_CONN_DONE = 8'h01;

   logic                  clock;
   logic                  reset;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [55:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int         mismatch_count;
   int         reports_due;
   bit         stall_on     = 1'b1;
   int         cycle_count  = 0;
   int         sent_bytes   = 0;
   logic [7:0] pkt[$];

   ble_adv_report_parser_unit u_dut (.*);

   adv_report_check u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up on a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // Receiver: stall at random while stalls are enabled
   always @(negedge clock) begin
      rsp_tready <= !(stall_on && $urandom_range(99) < IDLE_PCT);
   end

   // Send one byte and hold it until the parser takes the beat
   task automatic send_byte(input logic [7:0] value, input logic fin);
      while (stall_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = value;
      req_tlast  = fin;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_bytes++;
   endtask

   task automatic send_packet();
      int k;
      for (k = 0; k < pkt.size(); k++) send_byte(pkt[k], k == pkt.size() - 1);
   endtask

   // Hold off until every predicted report has arrived and the result walk is over
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic signed [7:0] value);
      wait_drained();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = THRESHOLD_ADDR;
      csr_pwdata  = {{24{value[7]}}, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Build an advertising report event with random content; data_total
   // data bytes are spread over the reports
   task automatic build_event(input int n_rep, input int data_total);
      int room;
      int len;
      int r;
      pkt.delete();
      pkt.push_back(8'($urandom));
      pkt.push_back(EVT_LE_META);
      pkt.push_back(8'($urandom));
      pkt.push_back(SUBEVT_ADV_REP);
      pkt.push_back(8'(n_rep));
      repeat ((2 + ADDR_BYTES) * n_rep) pkt.push_back(8'($urandom));
      room = data_total;
      for (r = 0; r < n_rep; r++) begin
         len = (r == n_rep - 1) ? room : $urandom_range(room < 255 ? room : 255);
         pkt.push_back(8'(len));
         room -= len;
      end
      repeat (data_total) pkt.push_back(8'($urandom));
      repeat (n_rep) pkt.push_back(8'($urandom));
   endtask

   initial begin
      int                k;
      int                n;
      int                room;
      int                kind;
      int                pkt_no;
      int                phase_no;
      logic signed [7:0] level;

      reset       = 1'b1;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      req_tvalid  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_threshold(8'sd0);

      // one report, all-ones address, no data
      build_event(1, 0);
      for (k = 0; k < ADDR_BYTES; k++) pkt[PKT_HDR + 2 + k] = 8'hFF;
      send_packet();
      // one report, all-zero address, some data
      build_event(1, 4);
      for (k = 0; k < ADDR_BYTES; k++) pkt[PKT_HDR + 2 + k] = 8'h00;
      send_packet();
      // accepted event without reports
      build_event(0, 0);
      send_packet();
      // foreign event code, then another LE sub-event
      build_event(2, 3);
      pkt[1] = EVT_CMD_COMPLETE;
      send_packet();
      build_event(2, 3);
      pkt[3] = SUBEVT_CONN_DONE;
      send_packet();
      // report count above the store size, then the top count value
      build_event(2, 0);
      pkt[4] = 8'(MAX_REPORTS + 1);
      send_packet();
      pkt[4] = 8'hFF;
      send_packet();
      // final byte before the RSSI section is complete
      build_event(3, 5);
      void'(pkt.pop_back());
      send_packet();
      // bytes after the RSSI section
      build_event(2, 2);
      repeat (3) pkt.push_back(8'($urandom));
      send_packet();
      // run the long window packets with both sides never idle
      stall_on = 1'b0;
      // exactly the packet window, then one byte past it
      build_event(1, MAX_PACKET_BYTES - PKT_HDR - REPORT_BYTES);
      send_packet();
      build_event(1, MAX_PACKET_BYTES - PKT_HDR - REPORT_BYTES + 1);
      send_packet();
      // most reports that fit the window, then the full report count
      build_event((MAX_PACKET_BYTES - PKT_HDR) / REPORT_BYTES, 0);
      send_packet();
      build_event(MAX_REPORTS, 0);
      send_packet();
      stall_on = 1'b1;
      // lone final byte
      pkt.delete();
      pkt.push_back(8'($urandom));
      send_packet();

      // filter edges: strongest threshold passes only rssi 127
      write_threshold(8'sd127);
      build_event(3, 0);
      pkt[pkt.size() - 3] = 8'd126;
      pkt[pkt.size() - 2] = 8'd125;
      pkt[pkt.size() - 1] = 8'd127;
      send_packet();
      // weakest threshold passes everything
      write_threshold(8'h80);
      build_event(3, 0);
      pkt[pkt.size() - 3] = 8'd127;
      pkt[pkt.size() - 2] = 8'd0;
      pkt[pkt.size() - 1] = 8'd128;
      send_packet();
      // threshold -60: equal passes, one below fails
      write_threshold(-8'sd60);
      build_event(3, 1);
      pkt[pkt.size() - 3] = 8'd194;
      pkt[pkt.size() - 2] = 8'd195;
      pkt[pkt.size() - 1] = 8'd255;
      send_packet();

      // Random events, mostly well formed, in phases of threshold settings
      pkt_no   = 0;
      phase_no = 0;
      sent_bytes = 0;
      while (sent_bytes < ITEMS) begin
         if (pkt_no % 6 == 0) begin
            case (phase_no % 6)
               0:       level = 8'sd0;
               1:       level = 8'h80;
               2:       level = -8'sd70;
               3:       level = 8'sd127;
               default: level = 8'($urandom_range(255));
            endcase
            write_threshold(level);
            stall_on = (phase_no % 4) != 2;
            phase_no++;
         end
         pkt_no++;

         n    = ($urandom_range(7) == 0) ? $urandom_range(25, 5) : $urandom_range(4, 1);
         room = MAX_PACKET_BYTES - PKT_HDR - REPORT_BYTES * n;
         room = ($urandom_range(3) == 0) ? $urandom_range(room)
                                         : $urandom_range(room < 12 ? room : 12);
         kind = $urandom_range(99);
         if (kind < 70) begin
            build_event(n, room);
            if ($urandom_range(9) == 0)
               repeat ($urandom_range(MAX_PACKET_BYTES - pkt.size())) pkt.push_back(8'($urandom));
         end else if (kind < 75) begin
            // cut short
            build_event(n, room);
            k = $urandom_range(pkt.size() - 1, 1);
            while (pkt.size() > k) void'(pkt.pop_back());
         end else if (kind < 80) begin
            // foreign code or sub-event
            build_event(n, room);
            k = $urandom_range(255);
            if ($urandom_range(1) == 0) pkt[1] = (8'(k) == EVT_LE_META) ? EVT_CMD_COMPLETE : 8'(k);
            else pkt[3] = (8'(k) == SUBEVT_ADV_REP) ? SUBEVT_CONN_DONE : 8'(k);
         end else if (kind < 85) begin
            build_event(n, room);
            pkt[4] = 8'($urandom_range(255, MAX_REPORTS + 1));
         end else if (kind < 90) begin
            // pad past the packet window
            build_event(n, room);
            k = $urandom_range(300, MAX_PACKET_BYTES + 1);
            while (pkt.size() < k) pkt.push_back(8'($urandom));
         end else if (kind < 95) begin
            build_event(0, 0);
            repeat ($urandom_range(3)) pkt.push_back(8'($urandom));
         end else begin
            pkt.delete();
            repeat ($urandom_range(20, 1)) pkt.push_back(8'($urandom));
         end
         send_packet();
      end

      wait_drained();
      if (mismatch_count == 0 && reports_due == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
